// ----- rtl/core/tpsb_pkg.sv -----
// Shared types and constants for the two-plane scrolling bitmap.
`default_nettype none

package tpsb_pkg;

  localparam int unsigned ColW   = 8;
  localparam int unsigned IndexW = 3;

  typedef enum logic [2:0] {
    OP_QUERY       = 3'd0,
    OP_SET_POINT   = 3'd1,
    OP_SET_OVERLAY = 3'd2,
    OP_ERASE       = 3'd3,
    OP_SHIFT_LO    = 3'd4,
    OP_SHIFT_HI    = 3'd5,
    OP_LOAD_COL    = 3'd6,
    OP_OVERLAY     = 3'd7
  } op_e;

  // Transaction as it travels down the row chain, collecting the addressed row words.
  typedef struct packed {
    op_e               op;
    logic [IndexW-1:0] row_index;
    logic [IndexW-1:0] col_index;
    logic              set_bit;
    logic [ColW-1:0]   map_column;
    logic [ColW-1:0]   coin_column;
    logic [ColW-1:0]   obstacle_row;
    logic [ColW-1:0]   overlay_row;
  } token_t;

endpackage

`default_nettype wire

// ----- rtl/core/tpsb_cell.sv -----
// One row cell: holds one row word of each plane and applies each passing transaction.
`default_nettype none

module tpsb_cell #(
  parameter int unsigned SIZE = 8,
  parameter int unsigned IDX  = 0
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire logic             tok_valid_i,
  input  wire tpsb_pkg::token_t tok_i,
  output logic                  tok_valid_o,
  output tpsb_pkg::token_t      tok_o
);

  localparam int unsigned BitPos = SIZE - 1 - IDX;

  logic [SIZE-1:0]  obst_q, obst_d;
  logic [SIZE-1:0]  ovl_q, ovl_d;
  logic             valid_q, valid_d;
  tpsb_pkg::token_t tok_q, tok_d;

  logic             row_hit;
  logic             col_ok;
  logic [SIZE-1:0]  mask;
  logic             map_bit;
  logic             coin_bit;
  logic             step;

  assign row_hit  = (32'(tok_i.row_index) == IDX);
  assign col_ok   = (32'(tok_i.col_index) < SIZE);
  assign mask     = col_ok ? (SIZE'(1) << tok_i.col_index) : '0;
  assign map_bit  = tok_i.map_column[BitPos];
  assign coin_bit = tok_i.coin_column[BitPos];
  assign step     = tok_valid_i && advance_i;

  always_comb begin
    obst_d = obst_q;
    ovl_d  = ovl_q;
    if (step) begin
      unique case (tok_i.op)
        tpsb_pkg::OP_SET_POINT: begin
          if (row_hit) begin
            obst_d = tok_i.set_bit ? (obst_q | mask) : (obst_q & ~mask);
          end
        end
        tpsb_pkg::OP_SET_OVERLAY: begin
          if (row_hit) begin
            ovl_d = ovl_q | mask;
          end
        end
        tpsb_pkg::OP_ERASE: begin
          if (row_hit) begin
            obst_d = obst_q & ~mask;
            ovl_d  = ovl_q & ~mask;
          end
        end
        tpsb_pkg::OP_SHIFT_LO: begin
          obst_d = {obst_q[SIZE-2:0], map_bit};
          ovl_d  = {ovl_q[SIZE-2:0], coin_bit};
        end
        tpsb_pkg::OP_SHIFT_HI: begin
          obst_d = {map_bit, obst_q[SIZE-1:1]};
          ovl_d  = {coin_bit, ovl_q[SIZE-1:1]};
        end
        tpsb_pkg::OP_LOAD_COL: begin
          // mask is empty when the column is out of range
          obst_d = map_bit ? (obst_q | mask) : (obst_q & ~mask);
          ovl_d  = coin_bit ? (ovl_q | mask) : (ovl_q & ~mask);
        end
        tpsb_pkg::OP_OVERLAY: begin
          obst_d = tok_i.set_bit ? (obst_q | ovl_q) : (obst_q & ~ovl_q);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    valid_d = valid_q;
    tok_d   = tok_q;
    if (advance_i) begin
      valid_d = tok_valid_i;
      tok_d   = tok_i;
      // capture the addressed row after this cell's update
      if (row_hit) begin
        tok_d.obstacle_row = tpsb_pkg::ColW'(obst_d);
        tok_d.overlay_row  = tpsb_pkg::ColW'(ovl_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obst_q  <= '0;
      ovl_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      obst_q  <= obst_d;
      ovl_q   <= ovl_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_valid_o = valid_q;
  assign tok_o       = tok_q;

endmodule

`default_nettype wire

// ----- rtl/core/two_plane_scrolling_bitmap.sv -----
// Top level: row-cell chain holding both bit planes, with a registered result stage.
//
//  channel | dir | handshake              | payload
//  in      | in  | in_valid_i / in_stall_o | op, row_index, col_index, set_bit, columns
//  out     | out | out_valid_o/ out_stall_i| obstacle_bit, overlay_bit, both row words
//
// A transaction walks the chain of SIZE row cells, one cell per cycle unless the chain is
// held, and then moves into the registered result stage; a new item is taken
// once the previous one has left the last cell, so only one item is in the chain at a time.
// Reset clears both planes and all valid flags.
// A stalled result holds the last cell's transaction; input stays stalled meanwhile.
`default_nettype none

module two_plane_scrolling_bitmap #(
  parameter int unsigned SIZE = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [2:0] op_i,
  input  wire logic [2:0] row_index_i,
  input  wire logic [2:0] col_index_i,
  input  wire logic       set_bit_i,
  input  wire logic [7:0] map_column_i,
  input  wire logic [7:0] coin_column_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            obstacle_bit_o,
  output logic            overlay_bit_o,
  output logic [7:0]      obstacle_row_o,
  output logic [7:0]      overlay_row_o
);

  logic [SIZE:0]    chain_v;
  tpsb_pkg::token_t chain_tok [SIZE+1];
  logic             busy;
  logic             advance;

  logic             out_valid_q, out_valid_d;
  tpsb_pkg::token_t res_q, res_d;

  assign busy       = |chain_v[SIZE:1];
  assign in_stall_o = busy;
  // hold the chain while the finished transaction cannot move into the result stage
  assign advance    = !(chain_v[SIZE] && out_valid_q && out_stall_i);

  assign chain_v[0]                = in_valid_i && !busy;
  assign chain_tok[0].op           = tpsb_pkg::op_e'(op_i);
  assign chain_tok[0].row_index    = row_index_i;
  assign chain_tok[0].col_index    = col_index_i;
  assign chain_tok[0].set_bit      = set_bit_i;
  assign chain_tok[0].map_column   = map_column_i;
  assign chain_tok[0].coin_column  = coin_column_i;
  assign chain_tok[0].obstacle_row = '0;
  assign chain_tok[0].overlay_row  = '0;

  for (genvar k = 0; k < SIZE; k++) begin : g_row
    tpsb_cell #(
      .SIZE(SIZE),
      .IDX (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .advance_i  (advance),
      .tok_valid_i(chain_v[k]),
      .tok_i      (chain_tok[k]),
      .tok_valid_o(chain_v[k+1]),
      .tok_o      (chain_tok[k+1])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (chain_v[SIZE] && advance) begin
      out_valid_d = 1'b1;
      res_d       = chain_tok[SIZE];
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // row words are zero outside the plane, so out-of-range points read as zero
  assign out_valid_o    = out_valid_q;
  assign obstacle_row_o = res_q.obstacle_row;
  assign overlay_row_o  = res_q.overlay_row;
  assign obstacle_bit_o = res_q.obstacle_row[res_q.col_index];
  assign overlay_bit_o  = res_q.overlay_row[res_q.col_index];

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the two-plane scrolling bitmap.
`timescale 1ns / 1ps

module testbench;

  localparam int SIZE = 8;
  localparam int HALF_PERIOD = 2;

  typedef struct packed {
    logic       obstacle_bit;
    logic       overlay_bit;
    logic [7:0] obstacle_row;
    logic [7:0] overlay_row;
  } view_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [2:0] op_in = '0;
  logic [2:0] row_in = '0;
  logic [2:0] col_in = '0;
  logic       set_bit_in = 1'b0;
  logic [7:0] map_col_in = '0;
  logic [7:0] coin_col_in = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       obstacle_bit;
  logic       overlay_bit;
  logic [7:0] obstacle_row;
  logic [7:0] overlay_row;

  // Local copy of both planes, one row word per row
  logic [7:0] obst_plane [SIZE];
  logic [7:0] ovl_plane [SIZE];

  view_t expected_views [$];
  int    err_count = 0;
  int    sent_count = 0;
  int    checked_count = 0;
  int    op_seen [8];
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    holdoff_left = 0;

  two_plane_scrolling_bitmap #(.SIZE(SIZE)) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (op_in),
    .row_index_i   (row_in),
    .col_index_i   (col_in),
    .set_bit_i     (set_bit_in),
    .map_column_i  (map_col_in),
    .coin_column_i (coin_col_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .obstacle_bit_o(obstacle_bit),
    .overlay_bit_o (overlay_bit),
    .obstacle_row_o(obstacle_row),
    .overlay_row_o (overlay_row)
  );

  always #HALF_PERIOD clk = ~clk;

  // Apply one operation to the local planes and return the view it leaves behind.
  function automatic view_t apply_bitmap_op(tpsb_pkg::op_e op, logic [2:0] row,
                                            logic [2:0] col, logic sb,
                                            logic [7:0] mcol, logic [7:0] ccol);
    view_t      v;
    logic       row_ok;
    logic       col_ok;
    logic [7:0] mask;
    logic [7:0] top_bit;
    logic [7:0] orow;
    logic [7:0] vrow;
    row_ok = (row < SIZE);
    col_ok = (col < SIZE);
    mask   = col_ok ? (8'd1 << col) : 8'd0;
    case (op)
      tpsb_pkg::OP_SET_POINT: begin
        if (row_ok && col_ok) begin
          obst_plane[row] = sb ? (obst_plane[row] | mask) : (obst_plane[row] & ~mask);
        end
      end
      tpsb_pkg::OP_SET_OVERLAY: begin
        if (row_ok && col_ok) ovl_plane[row] = ovl_plane[row] | mask;
      end
      tpsb_pkg::OP_ERASE: begin
        if (row_ok && col_ok) begin
          obst_plane[row] = obst_plane[row] & ~mask;
          ovl_plane[row]  = ovl_plane[row] & ~mask;
        end
      end
      tpsb_pkg::OP_SHIFT_LO: begin
        for (int r = 0; r < SIZE; r++) begin
          obst_plane[r] = {obst_plane[r][6:0], mcol[SIZE-1-r]};
          ovl_plane[r]  = {ovl_plane[r][6:0], ccol[SIZE-1-r]};
        end
      end
      tpsb_pkg::OP_SHIFT_HI: begin
        for (int r = 0; r < SIZE; r++) begin
          top_bit = '0;
          top_bit[SIZE-1] = mcol[SIZE-1-r];
          obst_plane[r] = (obst_plane[r] >> 1) | top_bit;
          top_bit = '0;
          top_bit[SIZE-1] = ccol[SIZE-1-r];
          ovl_plane[r] = (ovl_plane[r] >> 1) | top_bit;
        end
      end
      tpsb_pkg::OP_LOAD_COL: begin
        if (col_ok) begin
          for (int r = 0; r < SIZE; r++) begin
            obst_plane[r][col] = mcol[SIZE-1-r];
            ovl_plane[r][col]  = ccol[SIZE-1-r];
          end
        end
      end
      tpsb_pkg::OP_OVERLAY: begin
        for (int r = 0; r < SIZE; r++) begin
          obst_plane[r] = sb ? (obst_plane[r] | ovl_plane[r])
                             : (obst_plane[r] & ~ovl_plane[r]);
        end
      end
      default: ;
    endcase
    orow = row_ok ? obst_plane[row] : 8'd0;
    vrow = row_ok ? ovl_plane[row] : 8'd0;
    v.obstacle_bit = (row_ok && col_ok) ? orow[col] : 1'b0;
    v.overlay_bit  = (row_ok && col_ok) ? vrow[col] : 1'b0;
    v.obstacle_row = orow;
    v.overlay_row  = vrow;
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] exp_val, logic [7:0] got_val);
    $display("[%0t] MISMATCH %s: expected %h, got %h", $time, what, exp_val, got_val);
    err_count++;
  endtask

  // Offer one transaction; called at a falling edge, returns at a falling edge.
  task automatic send_item(tpsb_pkg::op_e op, logic [2:0] row, logic [2:0] col, logic sb,
                           logic [7:0] mcol, logic [7:0] ccol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    op_in       = op;
    row_in      = row;
    col_in      = col;
    set_bit_in  = sb;
    map_col_in  = mcol;
    coin_col_in = ccol;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_views.push_back(apply_bitmap_op(op, row, col, sb, mcol, ccol));
    op_seen[op]++;
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_random_item();
    send_item(tpsb_pkg::op_e'($urandom_range(7)), 3'($urandom_range(7)),
              3'($urandom_range(7)), 1'($urandom_range(1)),
              8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid = 1'b0;
    while (expected_views.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SIZE + 4) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver: random stalls, overridden by a counted hold-off
  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      out_stall = 1'b1;
      holdoff_left--;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    view_t exp_v;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_views.size() == 0) begin
        report_mismatch("result with nothing expected", 8'd0, 8'd0);
      end else begin
        exp_v = expected_views.pop_front();
        checked_count++;
        if (obstacle_bit !== exp_v.obstacle_bit)
          report_mismatch("obstacle_bit", 8'(exp_v.obstacle_bit), 8'(obstacle_bit));
        if (overlay_bit !== exp_v.overlay_bit)
          report_mismatch("overlay_bit", 8'(exp_v.overlay_bit), 8'(overlay_bit));
        if (obstacle_row !== exp_v.obstacle_row)
          report_mismatch("obstacle_row", exp_v.obstacle_row, obstacle_row);
        if (overlay_row !== exp_v.overlay_row)
          report_mismatch("overlay_row", exp_v.overlay_row, overlay_row);
      end
    end
  end

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(tpsb_pkg::OP_QUERY,       3'd0, 3'd0, 1'b0, 8'h00, 8'h00);
    send_item(tpsb_pkg::OP_SET_POINT,   3'd0, 3'd0, 1'b1, 8'hFF, 8'hFF);
    send_item(tpsb_pkg::OP_SET_POINT,   3'd7, 3'd7, 1'b1, 8'h00, 8'h00);
    send_item(tpsb_pkg::OP_SET_POINT,   3'd0, 3'd7, 1'b1, 8'h00, 8'h00);
    send_item(tpsb_pkg::OP_SET_POINT,   3'd7, 3'd0, 1'b1, 8'h00, 8'h00);
    send_item(tpsb_pkg::OP_SET_POINT,   3'd7, 3'd7, 1'b0, 8'h00, 8'h00);
    send_item(tpsb_pkg::OP_SET_OVERLAY, 3'd3, 3'd4, 1'b0, 8'h00, 8'h00);
    send_item(tpsb_pkg::OP_SET_OVERLAY, 3'd0, 3'd0, 1'b0, 8'hFF, 8'hFF);
    send_item(tpsb_pkg::OP_OVERLAY,     3'd3, 3'd4, 1'b1, 8'h00, 8'h00);
    send_item(tpsb_pkg::OP_QUERY,       3'd3, 3'd4, 1'b0, 8'h00, 8'h00);
    send_item(tpsb_pkg::OP_OVERLAY,     3'd0, 3'd0, 1'b0, 8'h00, 8'h00);
    send_item(tpsb_pkg::OP_ERASE,       3'd0, 3'd7, 1'b1, 8'hFF, 8'hFF);
    send_item(tpsb_pkg::OP_SHIFT_LO,    3'd0, 3'd0, 1'b0, 8'h80, 8'h01);
    send_item(tpsb_pkg::OP_SHIFT_LO,    3'd7, 3'd0, 1'b1, 8'hFF, 8'h00);
    send_item(tpsb_pkg::OP_SHIFT_HI,    3'd7, 3'd7, 1'b0, 8'h01, 8'h80);
    send_item(tpsb_pkg::OP_SHIFT_HI,    3'd0, 3'd7, 1'b0, 8'h00, 8'hFF);
    send_item(tpsb_pkg::OP_LOAD_COL,    3'd2, 3'd0, 1'b0, 8'hA5, 8'h5A);
    send_item(tpsb_pkg::OP_LOAD_COL,    3'd5, 3'd7, 1'b1, 8'hFF, 8'hFF);
    send_item(tpsb_pkg::OP_LOAD_COL,    3'd7, 3'd3, 1'b0, 8'h00, 8'h00);
    send_item(tpsb_pkg::OP_QUERY,       3'd7, 3'd7, 1'b1, 8'hFF, 8'hFF);
    send_item(tpsb_pkg::OP_ERASE,       3'd7, 3'd7, 1'b0, 8'h00, 8'h00);
    send_item(tpsb_pkg::OP_OVERLAY,     3'd5, 3'd7, 1'b1, 8'h00, 8'h00);
    send_item(tpsb_pkg::OP_OVERLAY,     3'd5, 3'd7, 1'b0, 8'hFF, 8'hFF);
    send_item(tpsb_pkg::OP_SHIFT_LO,    3'd4, 3'd2, 1'b0, 8'h00, 8'h00);
    wait_drained();
  endtask

  task automatic test_random(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_random_item();
    wait_drained();
  endtask

  // Hold the result side off long enough for the block to stall its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    holdoff_left = 300;
    @(negedge clk);
    repeat (24) send_random_item();
    wait_drained();
  endtask

  initial begin
    for (int r = 0; r < SIZE; r++) begin
      obst_plane[r] = '0;
      ovl_plane[r]  = '0;
    end
    for (int i = 0; i < 8; i++) op_seen[i] = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_random(270, 12, 69);
    test_random(270, 69, 12);
    test_random(270, 0, 0);
    test_backpressure();

    if (expected_views.size() != 0) begin
      report_mismatch("results never delivered", 8'(expected_views.size()), 8'd0);
    end
    $display("Covered %0d transactions, %0d results checked, under three idle mixes",
             sent_count, checked_count);
    $display("Ops: query %0d set %0d overlay %0d erase %0d shl %0d shr %0d load %0d show/hide %0d",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3],
             op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout waiting for the block");
    $display("Test completed with failures");
    $finish;
  end

endmodule
